/* sv/paged_breakpoint_watch_unit_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the paged breakpoint watch unit
// Shared property forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PAGED_BREAKPOINT_WATCH_UNIT_TOP_ASSERT_SVH
`define PAGED_BREAKPOINT_WATCH_UNIT_TOP_ASSERT_SVH

// Same-cycle implication
`define PBWU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbwu: same-cycle check failed");

// Next-cycle implication
`define PBWU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbwu: next-cycle check failed");

`endif

/* sv/pbwu_pkg.sv */
// ----------------------------------------------------------------------------
// pbwu_pkg
// Types, codes, sizes and entry helpers of the paged breakpoint watch unit.
// ----------------------------------------------------------------------------
package pbwu_pkg;

  // Sizes
  localparam int ENTRY_W        = 6;
  localparam int ADDR_W         = 16;
  localparam int GLOBAL_DEPTH   = 65536;
  localparam int SEG_OFS_W      = 14;
  localparam int SEG_SIZE       = 16384;
  localparam int SEG_NUM_W      = 4;
  localparam int SEG_CNT_W      = 9;
  localparam int PAGE_W         = 2;
  localparam int PAGE_COUNT     = 4;
  localparam int DATA_W         = 8;
  localparam int PRIO_W         = 2;
  localparam int THR_W          = 3;
  localparam int SEGMENT_COUNT_DEF = 16;

  // Configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_PRIORITY_THRESHOLD = 1'b0;

  // Entry layout
  localparam int BIT_IGNORE = 5;
  localparam logic [ENTRY_W-1:0] ACCESS_MASK   = 6'd7;
  localparam logic [ENTRY_W-1:0] PRIO_IGN_MASK = 6'd56;
  localparam logic [THR_W-1:0]   THR_OFF       = 3'd4;

  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [2:0] {
    OP_READ_CHK    = 3'd0,
    OP_WRITE_CHK   = 3'd1,
    OP_EXEC_CHK    = 3'd2,
    OP_SET_GLOBAL  = 3'd3,
    OP_SET_SEGMENT = 3'd4,
    OP_MAP_PAGE    = 3'd5
  } op_t;

  // Table port controls
  typedef struct packed {
    logic rd_en;
    logic g_we;
    logic s_we;
  } tbl_ctrl_t;

  // Merge a set request into an existing entry
  function automatic entry_t merge_entry(entry_t old, entry_t req);
    entry_t m;
    m = req;
    if (old > m) m = (old & PRIO_IGN_MASK) | (m & ACCESS_MASK);
    return m | (old & ACCESS_MASK);
  endfunction

  // Entry fires for the access bit at index sel
  function automatic logic fires(entry_t e, entry_t thr8, logic [1:0] sel);
    return (e >= thr8) && !e[BIT_IGNORE] && e[sel];
  endfunction

endpackage

/* sv/paged_breakpoint_watch_unit_top.sv */
// ----------------------------------------------------------------------------
// paged_breakpoint_watch_unit_top
// Breakpoint and watchpoint checks over a four-page memory, with a global
// per-address table, per-segment tables and a page-to-segment map.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  item      item_valid / item_ready     op, address, page, segment, data_value,
//                                        want_*, priority_req
//  result    result_valid / result_ready hit, hit_is_write, hit_address,
//                                        hit_value, ignore_flag
//  config    psel, penable, pwrite       paddr, pwdata, prdata (pready tied high)
//
//  For each item the memories are read at the accepting edge; the entry is
//  then merged and written back, with the result registered, in the S_EXEC
//  write-back cycle; the single read-modify-write sequence sets the rate.
//  After reset a clearing sweep over max(65536, SEGMENT_COUNT*16384) addresses
//  zeroes both tables (262144 at the default); no item is taken meanwhile.
//  A result held by result_ready low stalls the write-back cycle.
// ----------------------------------------------------------------------------
module paged_breakpoint_watch_unit_top
  import pbwu_pkg::*;
#(
  parameter int SEGMENT_COUNT = SEGMENT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // item channel
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [2:0]           op,
  input  logic [ADDR_W-1:0]    address,
  input  logic [PAGE_W-1:0]    page,
  input  logic [SEG_NUM_W-1:0] segment,
  input  logic [DATA_W-1:0]    data_value,
  input  logic                 want_read,
  input  logic                 want_write,
  input  logic                 want_execute,
  input  logic                 want_ignore,
  input  logic [PRIO_W-1:0]    priority_req,
  // result channel
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic                 hit,
  output logic                 hit_is_write,
  output logic [ADDR_W-1:0]    hit_address,
  output logic [DATA_W-1:0]    hit_value,
  output logic                 ignore_flag,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int SEG_ADDR_W = $clog2(SEGMENT_COUNT * SEG_SIZE);
  localparam int G_ADDR_W   = $clog2(GLOBAL_DEPTH);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t               state;
  logic [THR_W-1:0]     priority_threshold;
  logic [SEG_NUM_W-1:0] page_map [PAGE_COUNT];

  // Item held for the write-back cycle
  op_t                  op_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [PAGE_W-1:0]    page_q;
  logic [SEG_NUM_W-1:0] seg_q;
  logic [DATA_W-1:0]    val_q;
  entry_t               req_q;
  logic                 ok_a;
  logic                 ok_b;

  logic                 accept;
  logic                 finish;
  logic                 busy;
  tbl_ctrl_t            ctrl;
  logic [SEG_NUM_W-1:0] seg_a;
  logic [SEG_NUM_W-1:0] seg_b;
  logic [SEG_ADDR_W-1:0] s_raddr_a;
  logic [SEG_ADDR_W-1:0] s_raddr_b;
  logic [SEG_ADDR_W-1:0] s_waddr;
  entry_t               g_rdata;
  entry_t               s_rdata_a;
  entry_t               s_rdata_b;
  entry_t               old_entry;
  entry_t               wdata;
  entry_t               s_chk;
  entry_t               si_chk;
  entry_t               thr8;
  logic [THR_W-1:0]     thr_sat;
  logic                 is_check;
  logic                 hit_next;
  logic                 ign_next;
  logic                 cfg_wr;

  function automatic logic [SEG_ADDR_W-1:0] seg_index(logic [SEG_NUM_W-1:0] s,
                                                      logic [ADDR_W-1:0] a);
    return SEG_ADDR_W'({s, a[SEG_OFS_W-1:0]});
  endfunction

  function automatic logic seg_ok(logic [SEG_NUM_W-1:0] s);
    return SEG_CNT_W'(s) < SEG_CNT_W'(SEGMENT_COUNT);
  endfunction

  // Handshakes
  assign item_ready = (state == S_IDLE) && !busy;
  assign accept     = item_valid && item_ready;
  assign finish     = (state == S_EXEC) && (!result_valid || result_ready);

  // Read addresses from the incoming item
  assign seg_a     = (op == OP_SET_SEGMENT) ? segment : page_map[page];
  assign seg_b     = page_map[address[ADDR_W-1 -: PAGE_W]];
  assign s_raddr_a = seg_index(seg_a, address);
  assign s_raddr_b = seg_index(seg_b, address);
  assign s_waddr   = seg_index(seg_q, addr_q);

  // Merge the request into the old entry; an empty request clears it
  assign old_entry = (op_q == OP_SET_SEGMENT) ? s_rdata_a : g_rdata;
  assign wdata     = ((req_q & ~PRIO_IGN_MASK) == '0 && !req_q[BIT_IGNORE]) ?
                     '0 : merge_entry(old_entry, req_q);

  always_comb begin
    ctrl.rd_en = accept;
    ctrl.g_we  = finish && (op_q == OP_SET_GLOBAL);
    ctrl.s_we  = finish && (op_q == OP_SET_SEGMENT) && ok_a;
  end

  pbwu_tables #(
    .SEGMENT_COUNT(SEGMENT_COUNT)
  ) u_tables (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .g_raddr   (address[G_ADDR_W-1:0]),
    .s_raddr_a (s_raddr_a),
    .s_raddr_b (s_raddr_b),
    .g_waddr   (addr_q[G_ADDR_W-1:0]),
    .s_waddr   (s_waddr),
    .wdata     (wdata),
    .g_rdata   (g_rdata),
    .s_rdata_a (s_rdata_a),
    .s_rdata_b (s_rdata_b),
    .busy      (busy)
  );

  // Check: hit from the global entry or the segment the page slot maps; ignore also via the address page bits
  assign thr_sat  = (priority_threshold > THR_OFF) ? THR_OFF : priority_threshold;
  assign thr8     = {thr_sat, 3'b000};
  assign s_chk    = ok_a ? s_rdata_a : '0;
  assign si_chk   = ok_b ? s_rdata_b : '0;
  assign is_check = (op_q == OP_READ_CHK) || (op_q == OP_WRITE_CHK) ||
                    (op_q == OP_EXEC_CHK);
  assign hit_next = is_check && (fires(g_rdata, thr8, op_q[1:0]) ||
                                 fires(s_chk, thr8, op_q[1:0]));
  assign ign_next = is_check && (g_rdata[BIT_IGNORE] || si_chk[BIT_IGNORE]);

  // Control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      for (int i = 0; i < PAGE_COUNT; i++) page_map[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_EXEC;
          // drop the result once taken
          if (result_valid && result_ready) result_valid <= 1'b0;
        end
        S_EXEC: begin
          // a waiting result is never taken here without finish
          if (finish) begin
            state        <= S_IDLE;
            result_valid <= 1'b1;
            if (op_q == OP_MAP_PAGE) page_map[page_q] <= seg_q;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (finish) begin
      hit          <= hit_next;
      hit_is_write <= hit_next && (op_q == OP_WRITE_CHK);
      hit_address  <= is_check ? addr_q : '0;
      hit_value    <= is_check ? val_q : '0;
      ignore_flag  <= ign_next;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_t'(op);
      addr_q <= address;
      page_q <= page;
      seg_q  <= segment;
      val_q  <= data_value;
      req_q  <= {want_ignore, priority_req, want_execute, want_write, want_read};
      ok_a   <= seg_ok(seg_a);
      ok_b   <= seg_ok(seg_b);
    end
  end

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[PADDR_W-1:2] == REG_PRIORITY_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_threshold <= '0;
    end else if (cfg_wr) begin
      priority_threshold <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_PRIORITY_THRESHOLD) begin
      prdata = PDATA_W'(priority_threshold);
    end
  end

endmodule

/* sv/pbwu_tables.sv */
// ----------------------------------------------------------------------------
// pbwu_tables
// Global and segment breakpoint memories with registered reads and
// the clearing sweep that zeroes both after reset.
// ----------------------------------------------------------------------------
module pbwu_tables
  import pbwu_pkg::*;
#(
  parameter int SEGMENT_COUNT = SEGMENT_COUNT_DEF,
  localparam int SEG_DEPTH  = SEGMENT_COUNT * SEG_SIZE,
  localparam int SEG_ADDR_W = $clog2(SEG_DEPTH),
  localparam int G_ADDR_W   = $clog2(GLOBAL_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tbl_ctrl_t             ctrl,
  input  logic [G_ADDR_W-1:0]   g_raddr,
  input  logic [SEG_ADDR_W-1:0] s_raddr_a,
  input  logic [SEG_ADDR_W-1:0] s_raddr_b,
  input  logic [G_ADDR_W-1:0]   g_waddr,
  input  logic [SEG_ADDR_W-1:0] s_waddr,
  input  entry_t                wdata,
  output entry_t                g_rdata,
  output entry_t                s_rdata_a,
  output entry_t                s_rdata_b,
  output logic                  busy
);

  localparam int CLR_LEN = (SEG_DEPTH > GLOBAL_DEPTH) ? SEG_DEPTH : GLOBAL_DEPTH;
  localparam int CLR_W   = $clog2(CLR_LEN);

  entry_t gmem [GLOBAL_DEPTH];
  entry_t smem [SEG_DEPTH];

  logic [CLR_W-1:0] clr_cnt;
  logic             clearing;
  logic             clr_seg_ok;

  assign busy       = clearing;
  assign clr_seg_ok = ((CLR_W+1)'(clr_cnt) < (CLR_W+1)'(SEG_DEPTH));

  // Sweep both memories once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CLR_W'(CLR_LEN - 1)) clearing <= 1'b0;
    end
  end

  // Global table: write, then registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      gmem[clr_cnt[G_ADDR_W-1:0]] <= '0;
    end else if (ctrl.g_we) begin
      gmem[g_waddr] <= wdata;
    end
    if (ctrl.rd_en) g_rdata <= gmem[g_raddr];
  end

  // Segment table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_seg_ok) smem[clr_cnt[SEG_ADDR_W-1:0]] <= '0;
    end else if (ctrl.s_we) begin
      smem[s_waddr] <= wdata;
    end
    if (ctrl.rd_en) begin
      s_rdata_a <= smem[s_raddr_a];
      s_rdata_b <= smem[s_raddr_b];
    end
  end

endmodule

/* sv/pbwu_check.sv */
// ----------------------------------------------------------------------------
// pbwu_check
// Port-level checks of the paged breakpoint watch unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "paged_breakpoint_watch_unit_top_assert.svh"

module pbwu_check
  import pbwu_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic              hit,
  input logic              hit_is_write,
  input logic [ADDR_W-1:0] hit_address,
  input logic [DATA_W-1:0] hit_value,
  input logic              ignore_flag
);

  // A stalled result holds its payload
  `PBWU_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
    result_valid && $stable(hit) && $stable(hit_address) && $stable(hit_value) && $stable(ignore_flag))

  // A write flag only comes with a hit
  `PBWU_ASSERT_SAME(a_write_needs_hit, result_valid && hit_is_write, hit)

  // One transaction in flight: no accept in the cycle after an accept
  `PBWU_ASSERT_NEXT(a_single_flight, item_valid && item_ready, !item_ready)

  // The clearing sweep blocks items right after reset
  `PBWU_ASSERT_SAME(a_clear_blocks, $past(rst), !item_ready)

endmodule

bind paged_breakpoint_watch_unit_top pbwu_check u_pbwu_check (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .hit          (hit),
  .hit_is_write (hit_is_write),
  .hit_address  (hit_address),
  .hit_value    (hit_value),
  .ignore_flag  (ignore_flag)
);

/* tb/sv/paged_breakpoint_watch_unit_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paged_breakpoint_watch_unit_top_tb
// Self-checking bench for the paged breakpoint watch unit. A scoreboard
// model keeps its own global table, segment tables, page map and threshold,
// predicts the report of every accepted transaction, and compares each report
// the block returns with the oldest prediction. Directed cases come first,
// then a threshold sweep, random traffic and a backpressure phase.
// ----------------------------------------------------------------------------
module paged_breakpoint_watch_unit_top_tb;
  import pbwu_pkg::*;

  localparam int SEGMENT_COUNT  = SEGMENT_COUNT_DEF;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int MAX_SHOWN      = 10;

  // Op codes that the block leaves without effect
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Request bits, ordered {ignore, execute, write, read}
  localparam logic [3:0] W_NONE = 4'b0000;
  localparam logic [3:0] W_RD   = 4'b0001;
  localparam logic [3:0] W_WR   = 4'b0010;
  localparam logic [3:0] W_EX   = 4'b0100;
  localparam logic [3:0] W_IGN  = 4'b1000;
  localparam logic [3:0] W_RWX  = 4'b0111;

  typedef bit [ENTRY_W-1:0] wentry_t;
  localparam wentry_t IGN_MASK = wentry_t'(1) << BIT_IGNORE;

  typedef struct {
    logic [2:0]           op;
    logic [ADDR_W-1:0]    address;
    logic [PAGE_W-1:0]    page;
    logic [SEG_NUM_W-1:0] segment;
    logic [DATA_W-1:0]    data_value;
    logic                 want_read;
    logic                 want_write;
    logic                 want_execute;
    logic                 want_ignore;
    logic [PRIO_W-1:0]    priority_req;
  } watch_item_t;

  typedef struct packed {
    bit              hit;
    bit              is_write;
    bit [ADDR_W-1:0] addr;
    bit [DATA_W-1:0] value;
    bit              ign;
  } watch_report_t;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_ready;
  logic [2:0]           op;
  logic [ADDR_W-1:0]    address;
  logic [PAGE_W-1:0]    page;
  logic [SEG_NUM_W-1:0] segment;
  logic [DATA_W-1:0]    data_value;
  logic                 want_read;
  logic                 want_write;
  logic                 want_execute;
  logic                 want_ignore;
  logic [PRIO_W-1:0]    priority_req;
  logic                 result_valid;
  logic                 result_ready;
  logic                 hit;
  logic                 hit_is_write;
  logic [ADDR_W-1:0]    hit_address;
  logic [DATA_W-1:0]    hit_value;
  logic                 ignore_flag;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  paged_breakpoint_watch_unit_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .address      (address),
    .page         (page),
    .segment      (segment),
    .data_value   (data_value),
    .want_read    (want_read),
    .want_write   (want_write),
    .want_execute (want_execute),
    .want_ignore  (want_ignore),
    .priority_req (priority_req),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .hit          (hit),
    .hit_is_write (hit_is_write),
    .hit_address  (hit_address),
    .hit_value    (hit_value),
    .ignore_flag  (ignore_flag),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Scoreboard copy of the block state
  wentry_t          glob_tbl [GLOBAL_DEPTH];
  wentry_t          seg_tbl  [SEGMENT_COUNT*SEG_SIZE];
  bit [SEG_NUM_W-1:0] page_map_m [PAGE_COUNT];
  bit [THR_W-1:0]   thr_setting;

  watch_report_t    pending_reports[$];
  bit [SEG_OFS_W-1:0] hot_ofs [8];

  // Run control and statistics
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          rx_hold_req;
  bit          tx_valid_hi;
  int unsigned tx_gap;
  int unsigned sent_cnt;
  int unsigned checks_sent;
  int unsigned hits_seen;
  int unsigned reports_seen;
  int unsigned mismatch_cnt;
  int unsigned unexpected_cnt;
  int unsigned thr_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: the timeout covers the clearing sweep and the traffic, even with
  // every stall at its longest.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model
  // --------------------------------------------------------------------------
  function automatic wentry_t seg_entry(bit [SEG_NUM_W-1:0] seg, bit [SEG_OFS_W-1:0] ofs);
    if (seg >= SEGMENT_COUNT) return '0;
    return seg_tbl[seg * SEG_SIZE + ofs];
  endfunction

  function automatic bit entry_fires(wentry_t e, wentry_t thr8, wentry_t bitm);
    return (e >= thr8) && ((e & (IGN_MASK | bitm)) == bitm);
  endfunction

  // Higher entry supplies priority and ignore; access bits accumulate
  function automatic wentry_t merged(wentry_t old, wentry_t want);
    wentry_t keep;
    keep = (old > want) ? old : want;
    return (keep & PRIO_IGN_MASK) | (want & ACCESS_MASK) | (old & ACCESS_MASK);
  endfunction

  function automatic watch_report_t apply_to_tables(watch_item_t it);
    watch_report_t r;
    wentry_t       req, g, s, si, thr8, bitm;
    bit [THR_W-1:0] thr;
    bit            any_want;
    int unsigned   idx;
    r = '0;
    req = {it.want_ignore, it.priority_req, it.want_execute, it.want_write, it.want_read};
    any_want = it.want_read | it.want_write | it.want_execute | it.want_ignore;
    case (it.op)
      OP_READ_CHK, OP_WRITE_CHK, OP_EXEC_CHK: begin
        thr = (thr_setting > THR_OFF) ? THR_OFF : thr_setting;
        thr8 = {thr, 3'b000};
        bitm = wentry_t'(1) << it.op;
        g = glob_tbl[it.address];
        s = seg_entry(page_map_m[it.page], it.address[SEG_OFS_W-1:0]);
        si = seg_entry(page_map_m[it.address[ADDR_W-1:SEG_OFS_W]],
                       it.address[SEG_OFS_W-1:0]);
        r.hit = entry_fires(g, thr8, bitm) || entry_fires(s, thr8, bitm);
        r.is_write = r.hit && (it.op == OP_WRITE_CHK);
        r.ign = g[BIT_IGNORE] | si[BIT_IGNORE];
        r.addr = it.address;
        r.value = it.data_value;
      end
      OP_SET_GLOBAL: begin
        glob_tbl[it.address] = any_want ? merged(glob_tbl[it.address], req) : '0;
      end
      OP_SET_SEGMENT: begin
        if (it.segment < SEGMENT_COUNT) begin
          idx = it.segment * SEG_SIZE + it.address[SEG_OFS_W-1:0];
          seg_tbl[idx] = any_want ? merged(seg_tbl[idx], req) : '0;
        end
      end
      OP_MAP_PAGE: begin
        page_map_m[it.page] = it.segment;
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic watch_item_t mk_item(logic [2:0] o, logic [ADDR_W-1:0] a,
                                          logic [PAGE_W-1:0] pg,
                                          logic [SEG_NUM_W-1:0] sg,
                                          logic [DATA_W-1:0] d, logic [3:0] w,
                                          logic [PRIO_W-1:0] pr);
    watch_item_t it;
    it.op = o;
    it.address = a;
    it.page = pg;
    it.segment = sg;
    it.data_value = d;
    {it.want_ignore, it.want_execute, it.want_write, it.want_read} = w;
    it.priority_req = pr;
    return it;
  endfunction

  // Mostly addresses on the hot offsets, so that sets and checks meet
  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 3) != 0)
      return {PAGE_W'($urandom), hot_ofs[$urandom_range(0, 7)]};
    return ADDR_W'($urandom);
  endfunction

  function automatic watch_item_t random_item();
    watch_item_t it;
    int unsigned pick;
    it = mk_item(OP_READ_CHK, pick_address(), PAGE_W'($urandom), SEG_NUM_W'($urandom),
                 DATA_W'($urandom), 4'($urandom), PRIO_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.op = 3'($urandom_range(OP_READ_CHK, OP_EXEC_CHK));
    end else if (pick < 72) begin
      it.op = OP_SET_GLOBAL;
    end else if (pick < 90) begin
      it.op = OP_SET_SEGMENT;
      if ($urandom_range(0, 9) < 7) it.segment = page_map_m[$urandom_range(0, 3)];
    end else if (pick < 97) begin
      it.op = OP_MAP_PAGE;
    end else begin
      it.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end
    // Drop the request bits now and then to remove entries
    if ((it.op == OP_SET_GLOBAL || it.op == OP_SET_SEGMENT) && $urandom_range(0, 9) == 0)
      {it.want_ignore, it.want_execute, it.want_write, it.want_read} = W_NONE;
    return it;
  endfunction

  // Offer one transaction, hold it until accepted, then book its report
  task automatic send_item(input watch_item_t it);
    if (tx_gap > 0) repeat (tx_gap) @(posedge clk);
    item_valid   <= 1'b1;
    op           <= it.op;
    address      <= it.address;
    page         <= it.page;
    segment      <= it.segment;
    data_value   <= it.data_value;
    want_read    <= it.want_read;
    want_write   <= it.want_write;
    want_execute <= it.want_execute;
    want_ignore  <= it.want_ignore;
    priority_req <= it.priority_req;
    tx_valid_hi = 1'b1;
    do @(posedge clk); while (!item_ready);
    pending_reports.push_back(apply_to_tables(it));
    sent_cnt++;
    if (it.op <= OP_EXEC_CHK) checks_sent++;
    tx_gap = tx_idle_en ? $urandom_range(0, 6) : 0;
    if (tx_gap > 0) begin
      item_valid <= 1'b0;
      tx_valid_hi = 1'b0;
    end
  endtask

  // Drop valid and wait until every booked report has come back
  task automatic drain_reports();
    if (tx_valid_hi) begin
      item_valid <= 1'b0;
      tx_valid_hi = 1'b0;
    end
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Threshold register write over the configuration port, block idle
  task automatic write_threshold(input bit [THR_W-1:0] v);
    drain_reports();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_PRIORITY_THRESHOLD) << 2;
    pwdata  <= {(PDATA_W-THR_W)'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    thr_setting = v;
    thr_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    // empty tables
    send_item(mk_item(OP_READ_CHK,  16'h0000, 2'd0, 4'd0,  8'h00, W_NONE, 2'd0));
    // full-priority global entry at the top address
    send_item(mk_item(OP_SET_GLOBAL, 16'hFFFF, 2'd3, 4'd15, 8'hFF, W_RWX, 2'd3));
    send_item(mk_item(OP_READ_CHK,  16'hFFFF, 2'd3, 4'd0,  8'hFF, W_NONE, 2'd0));
    send_item(mk_item(OP_WRITE_CHK, 16'hFFFF, 2'd3, 4'd0,  8'hA5, W_NONE, 2'd0));
    send_item(mk_item(OP_EXEC_CHK,  16'hFFFF, 2'd0, 4'd0,  8'h5A, W_NONE, 2'd0));
    // ignore-only entry reports the flag but never fires
    send_item(mk_item(OP_SET_GLOBAL, 16'h0000, 2'd0, 4'd0, 8'h00, W_IGN, 2'd0));
    send_item(mk_item(OP_EXEC_CHK,  16'h0000, 2'd0, 4'd0,  8'h81, W_NONE, 2'd0));
    // merge: old priority wins over a lower request, access bits accumulate
    send_item(mk_item(OP_SET_GLOBAL, 16'h1234, 2'd0, 4'd0, 8'h00, W_RD, 2'd1));
    send_item(mk_item(OP_SET_GLOBAL, 16'h1234, 2'd0, 4'd0, 8'h00, W_WR, 2'd3));
    send_item(mk_item(OP_SET_GLOBAL, 16'h1234, 2'd0, 4'd0, 8'h00, W_EX, 2'd0));
    send_item(mk_item(OP_WRITE_CHK, 16'h1234, 2'd0, 4'd0,  8'h3C, W_NONE, 2'd0));
    // remove: empty request clears the entry
    send_item(mk_item(OP_SET_GLOBAL, 16'h1234, 2'd0, 4'd0, 8'h00, W_NONE, 2'd2));
    send_item(mk_item(OP_READ_CHK,  16'h1234, 2'd0, 4'd0,  8'hC3, W_NONE, 2'd0));
    // segment entry reached through the page map
    send_item(mk_item(OP_MAP_PAGE,  16'h0000, 2'd1, 4'd15, 8'h00, W_NONE, 2'd0));
    send_item(mk_item(OP_SET_SEGMENT, 16'hFFFF, 2'd0, 4'd15, 8'h00, W_WR, 2'd2));
    send_item(mk_item(OP_WRITE_CHK, 16'h7FFF, 2'd1, 4'd0,  8'h11, W_NONE, 2'd0));
    send_item(mk_item(OP_READ_CHK,  16'h7FFF, 2'd1, 4'd0,  8'h22, W_NONE, 2'd0));
    // ignore bit found through the page that the address bits select
    send_item(mk_item(OP_SET_SEGMENT, 16'h0001, 2'd0, 4'd15, 8'h00, W_IGN | W_RD, 2'd3));
    send_item(mk_item(OP_MAP_PAGE,  16'h0000, 2'd2, 4'd15, 8'h00, W_NONE, 2'd0));
    send_item(mk_item(OP_READ_CHK,  16'h8001, 2'd0, 4'd0,  8'h44, W_NONE, 2'd0));
    send_item(mk_item(OP_READ_CHK,  16'h4001, 2'd2, 4'd0,  8'h55, W_NONE, 2'd0));
    // unused op codes change nothing and report zeros
    send_item(mk_item(OP_UNUSED_LO, 16'hFFFF, 2'd3, 4'd15, 8'hFF, 4'b1111, 2'd3));
    send_item(mk_item(OP_UNUSED_HI, 16'h1234, 2'd1, 4'd7,  8'h99, W_RWX, 2'd1));
    // restore the default mapping
    send_item(mk_item(OP_MAP_PAGE,  16'h0000, 2'd1, 4'd0,  8'h00, W_NONE, 2'd0));
    send_item(mk_item(OP_MAP_PAGE,  16'h0000, 2'd2, 4'd0,  8'h00, W_NONE, 2'd0));
  endtask

  // One global and one segment entry per priority level, checked under every threshold value
  task automatic test_threshold_sweep();
    bit [THR_W-1:0] plan [8];
    logic [ADDR_W-1:0] a;
    int unsigned k;
    plan = '{3'd4, 3'd7, 3'd0, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3};
    for (int i = 0; i < 4; i++) begin
      send_item(mk_item(OP_SET_GLOBAL, {PAGE_W'(i), hot_ofs[i]}, 2'd0, 4'd0,
                        8'h00, W_RWX, PRIO_W'(i)));
      send_item(mk_item(OP_SET_SEGMENT, {PAGE_W'(i), hot_ofs[4+i]}, 2'd0, 4'd0,
                        8'h00, W_RWX, PRIO_W'(i)));
    end
    foreach (plan[t]) begin
      write_threshold(plan[t]);
      for (int j = 0; j < 6; j++) begin
        k = $urandom_range(0, 3);
        a = $urandom_range(0, 1) ? {PAGE_W'(k), hot_ofs[k]}
                                 : {PAGE_W'($urandom), hot_ofs[4+k]};
        send_item(mk_item(3'($urandom_range(OP_READ_CHK, OP_EXEC_CHK)), a,
                          PAGE_W'($urandom), SEG_NUM_W'($urandom), DATA_W'($urandom),
                          4'($urandom), PRIO_W'($urandom)));
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int c = 0; c < 5; c++) begin
      write_threshold((c == 0) ? 3'd0 : THR_W'($urandom_range(0, 7)));
      // first stretch runs with no idling on either side
      tx_idle_en = (c != 0) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (c != 0) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 52; i++) send_item(random_item());
    end
  endtask

  // Receiver holds off while items keep coming; then a full drain pause
  task automatic test_backpressure();
    drain_reports();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    tx_gap = 0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_item(random_item());
    drain_reports();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int i = 0; i < 20; i++) send_item(random_item());
  endtask

  // --------------------------------------------------------------------------
  // Report checker
  // --------------------------------------------------------------------------
  initial begin : report_checker
    watch_report_t got, want;
    int unsigned stall;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // long hold-off, counted here
      if (rx_hold_req) begin
        result_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      stall = rx_idle_en ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      got = '{hit, hit_is_write, hit_address, hit_value, ignore_flag};
      reports_seen++;
      if (got.hit) hits_seen++;
      if (pending_reports.size() == 0) begin
        unexpected_cnt++;
        if (unexpected_cnt + mismatch_cnt <= MAX_SHOWN)
          $display("%0t: report with no transaction outstanding: hit=%0b addr=%h",
                   $realtime, got.hit, got.addr);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (unexpected_cnt + mismatch_cnt <= MAX_SHOWN)
            $display({"%0t: mismatch exp hit=%0b wr=%0b addr=%h val=%h ign=%0b",
                      " | got hit=%0b wr=%0b addr=%h val=%h ign=%0b"}, $realtime,
                     want.hit, want.is_write, want.addr, want.value, want.ign,
                     got.hit, got.is_write, got.addr, got.value, got.ign);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_sequence
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    op           <= OP_READ_CHK;
    address      <= '0;
    page         <= '0;
    segment      <= '0;
    data_value   <= '0;
    want_read    <= 1'b0;
    want_write   <= 1'b0;
    want_execute <= 1'b0;
    want_ignore  <= 1'b0;
    priority_req <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    foreach (hot_ofs[i]) hot_ofs[i] = SEG_OFS_W'($urandom);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_threshold_sweep();
    test_random_traffic();
    test_backpressure();

    // settle and look for stray reports
    drain_reports();
    repeat (20) @(posedge clk);

    $display("Covered %0d transactions, %0d checks of which %0d fired, %0d reports.",
             sent_cnt, checks_sent, hits_seen, reports_seen);
    $display("Threshold written %0d times; %0d-cycle receiver hold and drain pause done.",
             thr_writes, RX_HOLD_CYCLES);
    if (mismatch_cnt == 0 && unexpected_cnt == 0 && pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
